// ----- rtl/masked_match_registry_table_core_defines.svh -----
// assertion macros for the registry table core
// used by the datapath module; no other dependencies
`ifndef MASKED_MATCH_REGISTRY_TABLE_CORE_DEFINES_SVH
`define MASKED_MATCH_REGISTRY_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MMRT_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("registry table check failed");

// next-cycle implication, checked out of reset
`define MMRT_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("registry table check failed");

`endif

// ----- rtl/mmrt_pkg.sv -----
// shared types and constants for the registry table core
// no dependencies
`default_nettype none

package mmrt_pkg;

    localparam int ENTRIES     = 16;
    localparam int LABEL_BYTES = 8;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LINK_W      = $clog2(ENTRIES + 2);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int HANDLE_W    = 4;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(ENTRIES);

    localparam logic [3:0] SEL_KIND  = 4'h1;
    localparam logic [3:0] SEL_IDENT = 4'h2;
    localparam logic [3:0] SEL_VALUE = 4'h4;
    localparam logic [3:0] SEL_LABEL = 4'h8;

    typedef enum logic [1:0] {
        CMD_ADD        = 2'd0,
        CMD_REMOVE     = 2'd1,
        CMD_FIND_FIRST = 2'd2,
        CMD_FIND_NEXT  = 2'd3
    } cmd_code_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic sel_in;       // link read addressed by the input handle
        logic capture;      // latch handle and its link
        logic load_crit;
        logic add;
        logic rm_head;
        logic load_p_head;
        logic load_p_link;
        logic step;
        logic unlink;
        logic rsp_full;
        logic rsp_miss;
        logic rsp_hit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic h_free;
        logic head_null;
        logic head_is_h;
        logic p_end;
        logic hit;
        logic link_is_h;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mmrt_ctrl.sv -----
// controller state machine for the registry table core
// depends on mmrt_pkg
`default_nettype none

module mmrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        command,
    input  mmrt_pkg::dp_stat_t st,
    output mmrt_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import mmrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_FIND   = 3'b010,
        S_UNLINK = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.sel_in = 1'b1;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (cmd_code_t'(command))
                        CMD_ADD:
                        begin
                            if (st.full)
                            begin
                                cmd.rsp_full = 1'b1;
                            end
                            else
                            begin
                                cmd.add = 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (st.h_free || st.head_null)
                            begin
                                cmd.rsp_miss = 1'b1;
                            end
                            else if (st.head_is_h)
                            begin
                                cmd.rm_head = 1'b1;
                            end
                            else
                            begin
                                cmd.load_p_head = 1'b1;
                                state_next      = S_UNLINK;
                            end
                        end
                        CMD_FIND_FIRST:
                        begin
                            cmd.load_crit   = 1'b1;
                            cmd.load_p_head = 1'b1;
                            state_next      = S_FIND;
                        end
                        CMD_FIND_NEXT:
                        begin
                            if (st.h_free)
                            begin
                                cmd.rsp_miss = 1'b1;
                            end
                            else
                            begin
                                cmd.load_p_link = 1'b1;
                                state_next      = S_FIND;
                            end
                        end
                        default:
                        begin
                            cmd.rsp_miss = 1'b1;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (st.p_end)
                begin
                    cmd.rsp_miss = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (st.hit)
                begin
                    cmd.rsp_hit = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_UNLINK:
            begin
                if (st.p_end)
                begin
                    cmd.rsp_miss = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (st.link_is_h)
                begin
                    cmd.unlink = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/mmrt_dp.sv -----
// datapath of the registry table core: slot stores, link table, walk pointer,
// saved find criteria and result register; depends on mmrt_pkg and the defines header
`default_nettype none
`include "masked_match_registry_table_core_defines.svh"

module mmrt_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  mmrt_pkg::dp_cmd_t  cmd,
    output mmrt_pkg::dp_stat_t st,
    input  logic [31:0]        entry_kind,
    input  logic [31:0]        entry_ident,
    input  logic [31:0]        entry_value,
    input  logic               match_value,
    input  logic [63:0]        entry_label,
    input  logic               use_label,
    input  logic [3:0]         slot_handle,
    output logic               done,
    output logic [1:0]         status,
    output logic [3:0]         result_handle,
    output logic [31:0]        found_kind,
    output logic [31:0]        found_ident,
    output logic [31:0]        found_value,
    output logic [63:0]        found_label
);
    import mmrt_pkg::*;

    // label ends at the first zero byte or after LABEL_BYTES bytes
    function automatic logic [63:0] norm_label(input logic [63:0] v);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= LABEL_BYTES || v[8*i +: 8] == 8'h00)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

    logic [31:0]       kind_mem  [ENTRIES];
    logic [31:0]       ident_mem [ENTRIES];
    logic [31:0]       value_mem [ENTRIES];
    logic [63:0]       label_mem [ENTRIES];
    logic [LINK_W-1:0] link_mem  [ENTRIES];

    logic [ENTRIES-1:0] free_reg;
    logic [LINK_W-1:0]  head_reg;
    logic [CNT_W-1:0]   used_count_reg;
    logic [LINK_W-1:0]  p_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [IDX_W-1:0]   h_reg;
    logic [LINK_W-1:0]  link_h_reg;

    logic [3:0]  mask_reg;
    logic [31:0] crit_kind_reg;
    logic [31:0] crit_ident_reg;
    logic [31:0] crit_value_reg;
    logic [63:0] crit_label_reg;

    logic        done_reg;
    logic [1:0]  status_reg;
    logic [3:0]  handle_reg;
    logic [31:0] fkind_reg;
    logic [31:0] fident_reg;
    logic [31:0] fvalue_reg;
    logic [63:0] flabel_reg;

    logic [63:0]       label_in;
    logic              h_in_ok;
    logic [IDX_W-1:0]  h_in_idx;
    logic [IDX_W-1:0]  p_idx;
    logic [IDX_W-1:0]  rd_idx;
    logic [LINK_W-1:0] link_rd;
    logic [IDX_W-1:0]  alloc_idx;

    assign label_in = norm_label(entry_label);
    assign h_in_ok  = (32'(slot_handle) < 32'(ENTRIES));
    assign h_in_idx = IDX_W'(slot_handle);
    assign p_idx    = p_reg[IDX_W-1:0];
    assign rd_idx   = cmd.sel_in ? h_in_idx : p_idx;
    assign link_rd  = link_mem[rd_idx];

    // lowest free slot
    always_comb
    begin
        alloc_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                alloc_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        st.full      = (used_count_reg >= CNT_W'(ENTRIES));
        st.h_free    = !h_in_ok || free_reg[h_in_idx];
        st.head_null = (head_reg >= LINK_NULL);
        st.head_is_h = h_in_ok && (head_reg == LINK_W'(slot_handle));
        st.p_end     = (p_reg >= LINK_NULL) || (n_reg == CNT_W'(ENTRIES));
        st.link_is_h = (link_rd == LINK_W'(h_reg));
        st.hit       = !((mask_reg & SEL_KIND) != '0 && kind_mem[p_idx] != crit_kind_reg)
                    && !((mask_reg & SEL_IDENT) != '0 && ident_mem[p_idx] != crit_ident_reg)
                    && !((mask_reg & SEL_VALUE) != '0 && value_mem[p_idx] != crit_value_reg)
                    && !((mask_reg & SEL_LABEL) != '0 && label_mem[p_idx] != crit_label_reg);
    end

    // slot stores and link table carry no reset: free bits decide liveness
    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            kind_mem[alloc_idx]  <= entry_kind;
            ident_mem[alloc_idx] <= entry_ident;
            value_mem[alloc_idx] <= entry_value;
            label_mem[alloc_idx] <= use_label ? label_in : 64'd0;
            link_mem[alloc_idx]  <= head_reg;
        end
        else if (cmd.unlink)
        begin
            link_mem[p_idx] <= link_h_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            h_reg      <= h_in_idx;
            link_h_reg <= link_rd;
        end
        if (cmd.load_crit)
        begin
            crit_kind_reg  <= entry_kind;
            crit_ident_reg <= entry_ident;
            crit_value_reg <= entry_value;
            crit_label_reg <= label_in;
        end
        if (cmd.load_p_head)
        begin
            p_reg <= head_reg;
            n_reg <= '0;
        end
        else if (cmd.load_p_link)
        begin
            p_reg <= link_rd;
            n_reg <= '0;
        end
        else if (cmd.step)
        begin
            p_reg <= link_rd;
            n_reg <= n_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg       <= '1;
            head_reg       <= LINK_NULL;
            used_count_reg <= '0;
            mask_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.add || cmd.rm_head || cmd.unlink || cmd.rsp_full
                     || cmd.rsp_miss || cmd.rsp_hit;
            if (cmd.load_crit)
            begin
                mask_reg <= ((entry_kind != 32'd0) ? SEL_KIND : 4'h0)
                          | ((entry_ident != 32'd0) ? SEL_IDENT : 4'h0)
                          | (match_value ? SEL_VALUE : 4'h0)
                          | (use_label ? SEL_LABEL : 4'h0);
            end
            if (cmd.add)
            begin
                free_reg[alloc_idx] <= 1'b0;
                head_reg            <= LINK_W'(alloc_idx);
                used_count_reg      <= used_count_reg + CNT_W'(1);
            end
            else if (cmd.rm_head)
            begin
                free_reg[h_in_idx] <= 1'b1;
                head_reg           <= link_rd;
                used_count_reg     <= used_count_reg - CNT_W'(1);
            end
            else if (cmd.unlink)
            begin
                free_reg[h_reg] <= 1'b1;
                used_count_reg  <= used_count_reg - CNT_W'(1);
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        fkind_reg  <= '0;
        fident_reg <= '0;
        fvalue_reg <= '0;
        flabel_reg <= '0;
        status_reg <= ST_MISS;
        handle_reg <= '0;
        if (cmd.add)
        begin
            status_reg <= ST_OK;
            handle_reg <= HANDLE_W'(alloc_idx);
        end
        else if (cmd.rm_head)
        begin
            status_reg <= ST_OK;
            handle_reg <= HANDLE_W'(h_in_idx);
        end
        else if (cmd.unlink)
        begin
            status_reg <= ST_OK;
            handle_reg <= HANDLE_W'(h_reg);
        end
        else if (cmd.rsp_full)
        begin
            status_reg <= ST_FULL;
        end
        else if (cmd.rsp_hit)
        begin
            status_reg <= ST_OK;
            handle_reg <= HANDLE_W'(p_idx);
            fkind_reg  <= kind_mem[p_idx];
            fident_reg <= ident_mem[p_idx];
            fvalue_reg <= value_mem[p_idx];
            flabel_reg <= label_mem[p_idx];
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign result_handle = handle_reg;
    assign found_kind    = fkind_reg;
    assign found_ident   = fident_reg;
    assign found_value   = fvalue_reg;
    assign found_label   = flabel_reg;

    `MMRT_ASSERT_IMP(a_count_matches_free, clk, rst_n, 1'b1, ($countones(free_reg) + int'(used_count_reg)) == ENTRIES)
    `MMRT_ASSERT_IMP(a_head_is_live, clk, rst_n, head_reg < LINK_NULL, !free_reg[head_reg[IDX_W-1:0]])
    `MMRT_ASSERT_IMP(a_error_zero_payload, clk, rst_n, done_reg && status_reg != ST_OK, handle_reg == '0 && fkind_reg == '0 && flabel_reg == '0)
    `MMRT_ASSERT_NXT(a_unlink_frees, clk, rst_n, cmd.unlink, free_reg[$past(h_reg)] && done_reg)

endmodule

`default_nettype wire

// ----- rtl/masked_match_registry_table_core.sv -----
// Registry table core: 16 slots of kind, ident, data word and packed label,
// linked newest first. Commands: add, remove by handle, find first, find next.
//
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; all command fields are sampled at that edge only.
// Result channel: done pulses for one cycle with status, result_handle and the
// found fields; the receiver cannot stall, so every result is taken as shown.
// Add, a rejected command and removal of the newest entry answer in the
// next cycle. Remove of an older entry and both finds walk the list one entry
// per cycle through a single link table read port: they load the walk pointer,
// visit up to 16 entries and then answer.
// A new command is taken the cycle after the walk ends, while the previous
// result is still on the result ports.
// Reset: every slot free, list empty, find mask cleared; no clearing pass,
// the block takes commands in the first cycle after reset.
// Depends on mmrt_pkg, mmrt_ctrl and mmrt_dp.
`default_nettype none

module masked_match_registry_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] entry_kind,
    input  logic [31:0] entry_ident,
    input  logic [31:0] entry_value,
    input  logic        match_value,
    input  logic [63:0] entry_label,
    input  logic        use_label,
    input  logic [3:0]  slot_handle,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  result_handle,
    output logic [31:0] found_kind,
    output logic [31:0] found_ident,
    output logic [31:0] found_value,
    output logic [63:0] found_label
);
    import mmrt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t st;

    mmrt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .st      (st),
        .cmd     (cmd),
        .busy    (busy)
    );

    mmrt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .entry_kind    (entry_kind),
        .entry_ident   (entry_ident),
        .entry_value   (entry_value),
        .match_value   (match_value),
        .entry_label   (entry_label),
        .use_label     (use_label),
        .slot_handle   (slot_handle),
        .done          (done),
        .status        (status),
        .result_handle (result_handle),
        .found_kind    (found_kind),
        .found_ident   (found_ident),
        .found_value   (found_value),
        .found_label   (found_label)
    );

endmodule

`default_nettype wire
